// ===== rtl/core/tzx_pkg.sv =====
package tzx_pkg;

  // End-of-stream status codes, also used as the recorded stop cause.
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusBadSig    = 3'd1;
  localparam logic [2:0] StatusNoBlocks  = 3'd2;
  localparam logic [2:0] StatusTruncated = 3'd3;
  localparam logic [2:0] StatusUnknownId = 3'd4;

  localparam int unsigned BlockCountBitsDefault = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxResults = 3;

  // One output word.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [2:0]  status;
    logic [15:0] blocks;
  } res_t;

  // All the words caused by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    res_t [MaxResults-1:0] items;
  } bundle_t;

endpackage

// ===== rtl/core/tzx_front.sv =====
module tzx_front #(
  parameter int unsigned BLOCK_COUNT_BITS = tzx_pkg::BlockCountBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              last_in_file_i,
  input  logic              full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output tzx_pkg::bundle_t  bundle_o
);

  typedef enum logic [3:0] {
    PhSig,
    PhId,
    PhHdr,
    PhSkip,
    PhData,
    PhStop
  } phase_e;

  typedef struct packed {
    logic       known;
    logic [4:0] hdr;
    logic [4:0] loff;
    logic [2:0] lsz;
    logic [1:0] mult;
  } layout_t;

  localparam logic [7:0] IdStandard  = 8'h10;
  localparam logic [7:0] IdTurbo     = 8'h11;
  localparam logic [7:0] IdTone      = 8'h12;
  localparam logic [7:0] IdPulses    = 8'h13;
  localparam logic [7:0] IdPureData  = 8'h14;
  localparam logic [7:0] IdDirectRec = 8'h15;
  localparam logic [7:0] IdPause     = 8'h20;
  localparam logic [7:0] IdGroupBeg  = 8'h21;
  localparam logic [7:0] IdGroupEnd  = 8'h22;
  localparam logic [7:0] IdJump      = 8'h23;
  localparam logic [7:0] IdLoopBeg   = 8'h24;
  localparam logic [7:0] IdLoopEnd   = 8'h25;
  localparam logic [7:0] IdCallSeq   = 8'h26;
  localparam logic [7:0] IdReturn    = 8'h27;
  localparam logic [7:0] IdSelect    = 8'h28;
  localparam logic [7:0] IdStop48k   = 8'h2A;
  localparam logic [7:0] IdSetLevel  = 8'h2B;
  localparam logic [7:0] IdText      = 8'h30;
  localparam logic [7:0] IdMessage   = 8'h31;
  localparam logic [7:0] IdArchive   = 8'h32;
  localparam logic [7:0] IdHardware  = 8'h33;
  localparam logic [7:0] IdCustom    = 8'h35;
  localparam logic [7:0] IdGlue      = 8'h5A;

  localparam logic [4:0] SigLen    = 5'd8;
  localparam logic [4:0] HeaderLen = 5'd10;
  localparam int unsigned WideW = (BLOCK_COUNT_BITS > 16) ? BLOCK_COUNT_BITS : 16;
  localparam logic [BLOCK_COUNT_BITS-1:0] CountCap = '1;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    sig_byte = 8'h5A;
      3'd1:    sig_byte = 8'h58;
      3'd2:    sig_byte = 8'h54;
      3'd3:    sig_byte = 8'h61;
      3'd4:    sig_byte = 8'h70;
      3'd5:    sig_byte = 8'h65;
      3'd6:    sig_byte = 8'h21;
      default: sig_byte = 8'h1A;
    endcase
  endfunction

  function automatic layout_t mk_layout(input logic [4:0] hdr, input logic [4:0] loff,
                                        input logic [2:0] lsz, input logic [1:0] mult);
    layout_t l;
    l.known = 1'b1;
    l.hdr   = hdr;
    l.loff  = loff;
    l.lsz   = lsz;
    l.mult  = mult;
    return l;
  endfunction

  function automatic layout_t id_layout(input logic [7:0] id);
    layout_t l;
    l = '0;
    case (id)
      IdStandard:  l = mk_layout(5'd4, 5'd2, 3'd2, 2'd1);
      IdTurbo:     l = mk_layout(5'd18, 5'd15, 3'd3, 2'd1);
      IdTone:      l = mk_layout(5'd4, 5'd0, 3'd0, 2'd1);
      IdPulses:    l = mk_layout(5'd1, 5'd0, 3'd1, 2'd2);
      IdPureData:  l = mk_layout(5'd10, 5'd7, 3'd3, 2'd1);
      IdDirectRec: l = mk_layout(5'd8, 5'd5, 3'd3, 2'd1);
      IdPause, IdJump, IdLoopBeg:
                   l = mk_layout(5'd2, 5'd0, 3'd0, 2'd1);
      IdGroupBeg, IdText, IdMessage:
                   l = mk_layout(5'd1, 5'd0, 3'd1, 2'd1);
      IdGroupEnd, IdLoopEnd, IdReturn:
                   l = mk_layout(5'd0, 5'd0, 3'd0, 2'd1);
      IdCallSeq:   l = mk_layout(5'd2, 5'd0, 3'd2, 2'd2);
      IdSelect, IdArchive:
                   l = mk_layout(5'd2, 5'd0, 3'd2, 2'd1);
      IdStop48k:   l = mk_layout(5'd4, 5'd0, 3'd0, 2'd1);
      IdSetLevel:  l = mk_layout(5'd5, 5'd0, 3'd0, 2'd1);
      IdHardware:  l = mk_layout(5'd1, 5'd0, 3'd1, 2'd3);
      IdCustom:    l = mk_layout(5'd20, 5'd16, 3'd4, 2'd1);
      IdGlue:      l = mk_layout(5'd9, 5'd0, 3'd0, 2'd1);
      default:     l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [15:0] shown(input logic [BLOCK_COUNT_BITS-1:0] cnt);
    logic [WideW-1:0] wide;
    wide = WideW'(cnt);
    if (wide > WideW'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return wide[15:0];
  endfunction

  function automatic tzx_pkg::res_t mk_res(input logic kind, input logic [7:0] data,
                                           input logic first, input logic last,
                                           input logic [2:0] status,
                                           input logic [15:0] blocks);
    tzx_pkg::res_t r;
    r.kind   = kind;
    r.data   = data;
    r.first  = first;
    r.last   = last;
    r.status = status;
    r.blocks = blocks;
    return r;
  endfunction

  phase_e                    phase_q, phase_d;
  logic [4:0]                off_q, off_d;
  logic [7:0]                id_q, id_d;
  logic [31:0]               gather_q, gather_d;
  logic [31:0]               rem_q, rem_d;
  logic [7:0]                xor_q, xor_d;
  logic [BLOCK_COUNT_BITS-1:0] blocks_q, blocks_d;
  logic [2:0]                stop_q, stop_d;

  logic                      accept;
  layout_t                   lay;
  logic [4:0]                off_inc;
  logic [4:0]                rel;
  logic [5:0]                lend;
  logic [31:0]               gnew;
  logic [31:0]               skip_len;
  logic [2:0]                status;
  logic [1:0]                n;
  tzx_pkg::bundle_t          bundle;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept && (bundle.cnt != 2'd0);
  assign bundle_o   = bundle;

  always_comb begin
    phase_d  = phase_q;
    off_d    = off_q;
    id_d     = id_q;
    gather_d = gather_q;
    rem_d    = rem_q;
    xor_d    = xor_q;
    blocks_d = blocks_q;
    stop_d   = stop_q;
    n        = 2'd0;
    bundle   = '0;
    status   = tzx_pkg::StatusOk;
    off_inc  = off_q + 5'd1;
    lay      = id_layout((phase_q == PhId) ? in_byte_i : id_q);
    rel      = off_q - lay.loff;
    lend     = {1'b0, lay.loff} + {3'b000, lay.lsz};
    gnew     = gather_q;
    skip_len = '0;

    case (phase_q)
      PhSig: begin
        if (off_q < SigLen && in_byte_i != sig_byte(off_q[2:0])) begin
          phase_d = PhStop;
          stop_d  = tzx_pkg::StatusBadSig;
        end else if (off_inc >= HeaderLen) begin
          phase_d = PhId;
          off_d   = '0;
        end else begin
          off_d = off_inc;
        end
      end
      PhId: begin
        id_d = in_byte_i;
        if (!lay.known) begin
          phase_d = PhStop;
          stop_d  = tzx_pkg::StatusUnknownId;
        end else if (lay.hdr != 5'd0) begin
          phase_d  = PhHdr;
          off_d    = '0;
          gather_d = '0;
        end
      end
      PhHdr: begin
        if (off_q >= lay.loff && {1'b0, off_q} < lend) begin
          gnew[rel[1:0]*8 +: 8] = in_byte_i;
        end
        gather_d = gnew;
        off_d    = off_inc;
        if (off_inc >= lay.hdr) begin
          off_d = '0;
          if (id_q == IdStandard && gnew >= 32'd3) begin
            bundle.items[0] = mk_res(1'b0, gnew[7:0], 1'b1, 1'b0, tzx_pkg::StatusOk,
                                     shown(blocks_q));
            bundle.items[1] = mk_res(1'b0, gnew[15:8], 1'b0, 1'b0, tzx_pkg::StatusOk,
                                     shown(blocks_q));
            n       = 2'd2;
            rem_d   = gnew;
            xor_d   = '0;
            phase_d = PhData;
          end else begin
            case (lay.mult)
              2'd2:    skip_len = {gnew[30:0], 1'b0};
              2'd3:    skip_len = gnew + {gnew[30:0], 1'b0};
              default: skip_len = gnew;
            endcase
            rem_d   = skip_len;
            phase_d = (skip_len != 32'd0) ? PhSkip : PhId;
          end
        end
      end
      PhSkip: begin
        if (rem_q != 32'd0) begin
          rem_d = rem_q - 32'd1;
        end
        if (rem_d == 32'd0) begin
          phase_d = PhId;
        end
      end
      PhData: begin
        if (rem_q <= 32'd1) begin
          if (blocks_q != CountCap) begin
            blocks_d = blocks_q + 1'b1;
          end
          bundle.items[0] = mk_res(1'b0, xor_q, 1'b0, 1'b1, tzx_pkg::StatusOk,
                                   shown(blocks_d));
          n       = 2'd1;
          rem_d   = '0;
          phase_d = PhId;
        end else begin
          xor_d = xor_q ^ in_byte_i;
          bundle.items[0] = mk_res(1'b0, in_byte_i, 1'b0, 1'b0, tzx_pkg::StatusOk,
                                   shown(blocks_q));
          n     = 2'd1;
          rem_d = rem_q - 32'd1;
        end
      end
      PhStop: begin
      end
      default: begin
        phase_d = PhStop;
      end
    endcase

    if (last_in_file_i) begin
      if (phase_d == PhSig || stop_d == tzx_pkg::StatusBadSig) begin
        status = tzx_pkg::StatusBadSig;
      end else if (phase_d == PhData) begin
        status = tzx_pkg::StatusTruncated;
      end else if (blocks_d == '0) begin
        status = tzx_pkg::StatusNoBlocks;
      end else if (stop_d == tzx_pkg::StatusUnknownId) begin
        status = tzx_pkg::StatusUnknownId;
      end else begin
        status = tzx_pkg::StatusOk;
      end
      bundle.items[n] = mk_res(1'b1, 8'h00, 1'b0, 1'b0, status, shown(blocks_d));
      n        = n + 2'd1;
      // The report starts a fresh image.
      phase_d  = PhSig;
      off_d    = '0;
      id_d     = '0;
      gather_d = '0;
      rem_d    = '0;
      xor_d    = '0;
      blocks_d = '0;
      stop_d   = tzx_pkg::StatusOk;
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSig;
      off_q    <= '0;
      id_q     <= '0;
      gather_q <= '0;
      rem_q    <= '0;
      xor_q    <= '0;
      blocks_q <= '0;
      stop_q   <= tzx_pkg::StatusOk;
    end else if (accept) begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      id_q     <= id_d;
      gather_q <= gather_d;
      rem_q    <= rem_d;
      xor_q    <= xor_d;
      blocks_q <= blocks_d;
      stop_q   <= stop_d;
    end
  end

endmodule

// ===== rtl/core/tzx_queue.sv =====
module tzx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tzx_pkg::bundle_t wdata_i,
  input  logic             pop_i,
  output tzx_pkg::bundle_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(tzx_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(tzx_pkg::QueueDepth + 1);

  tzx_pkg::bundle_t      mem_q [tzx_pkg::QueueDepth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(tzx_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tzx_back.sv =====
module tzx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tzx_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output tzx_pkg::res_t    res_o
);

  tzx_pkg::bundle_t cur_q;
  logic [1:0]       idx_q;
  logic             valid_q;
  logic             final_word;

  assign final_word  = (idx_q == cur_q.cnt - 2'd1);
  assign pop_o       = !empty_i && (!valid_q || (out_ready_i && final_word));
  assign out_valid_o = valid_q;
  assign res_o       = cur_q.items[idx_q];

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (final_word) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/tzx_to_tap_stream_converter.sv =====
// A word is registered first in its queue entry and then in the output register before it is
// offered. One TZX byte per cycle is taken while the queue is not full; the byte that closes a
// standard block header of length three or more yields two words, the final byte one more, and
// the output port sets the pace. A four-entry queue of per-byte word groups sits between parser
// and output sequencer. Reset (rst_ni low, asynchronous) returns the parser to the signature
// check and empties the queue and the output register.
module tzx_to_tap_stream_converter #(
  parameter int unsigned BLOCK_COUNT_BITS = tzx_pkg::BlockCountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_in_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        block_first_o,
  output logic        block_last_o,
  output logic [2:0]  end_status_o,
  output logic [15:0] blocks_done_o
);

  // The front parser decides, for every byte, the whole group of words it causes
  // (pass-through data, length prefix, computed checksum, end report) and pushes that
  // group as one queue entry. Bytes that cause nothing are consumed without a push.
  tzx_pkg::bundle_t push_bundle;
  tzx_pkg::bundle_t head_bundle;
  tzx_pkg::res_t    res;
  logic             push, pop, full, empty;

  tzx_front #(
    .BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_i      (in_byte_i),
    .last_in_file_i (last_in_file_i),
    .full_i         (full),
    .in_ready_o     (in_ready_o),
    .push_o         (push),
    .bundle_o       (push_bundle)
  );

  // The queue lets the parser keep taking bytes while the output side is stalled.
  tzx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .pop_i   (pop),
    .rdata_o (head_bundle),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back end holds one group in its output register and hands its words out in
  // order, loading the next group, if one is queued, in the same cycle the last word is taken.
  tzx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign out_kind_o    = res.kind;
  assign out_byte_o    = res.data;
  assign block_first_o = res.first;
  assign block_last_o  = res.last;
  assign end_status_o  = res.status;
  assign blocks_done_o = res.blocks;

endmodule

// ===== rtl/core/tzx_checker.sv =====
module tzx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        out_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        block_first_o,
  input logic        block_last_o,
  input logic [2:0]  end_status_o,
  input logic [15:0] blocks_done_o
);

  // A stalled word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_kind_o) && $stable(end_status_o) && $stable(blocks_done_o))
    else $error("stalled output word changed");

  // A report carries no TAP byte or block markers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> out_byte_o == 8'h00 && !block_first_o && !block_last_o)
    else $error("report word carries TAP fields");

  // A TAP byte carries no status, and a status is always a defined one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_kind_o && end_status_o == tzx_pkg::StatusOk)
      || (out_kind_o && end_status_o <= tzx_pkg::StatusUnknownId))
    else $error("bad end status");

  // The opening length byte is followed by the high length byte, never by a close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && block_first_o |=> !out_valid_o
      || (!out_kind_o && !block_first_o && !block_last_o))
    else $error("block opened without high length byte");

  // A block never opens and closes on the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(block_first_o && block_last_o))
    else $error("first and last marked together");

endmodule

bind tzx_to_tap_stream_converter tzx_checker u_tzx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_kind_o    (out_kind_o),
  .out_byte_o    (out_byte_o),
  .block_first_o (block_first_o),
  .block_last_o  (block_last_o),
  .end_status_o  (end_status_o),
  .blocks_done_o (blocks_done_o)
);
